/* rtl/bst_pkg.sv */
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the binary semaphore table.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int NUM_SEMS_DEF = 64;
    localparam int ID_BITS_DEF  = 16;
    localparam int FIRST_ID     = 1;

    // request payload widths
    localparam int KIND_W   = 2;
    localparam int SEM_ID_W = 16;

    // response payload widths
    localparam int STATUS_W = 3;
    localparam int NEW_ID_W = 16;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC   = 2'd0,
        K_FREE    = 2'd1,
        K_DOWN    = 2'd2,
        K_UP      = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BUSY      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    // sequencer to table
    typedef struct packed {
        logic rd_en;
        logic clr_rd;
        logic mode_alloc;
        logic do_alloc;
        logic do_free;
        logic do_take;
        logic do_release;
    } tbl_cmd_t;

    // table to sequencer
    typedef struct packed {
        logic rd_vld;
        logic hit;
        logic hit_rel;
        logic last;
    } tbl_stat_t;

endpackage

/* rtl/bst_req_if.sv */
// ----------------------------------------------------------------------------
// bst_req_if
// Request channel: valid/ready handshake with kind and semaphore id.
// ----------------------------------------------------------------------------
interface bst_req_if;
    logic                         valid;
    logic                         ready;
    logic [bst_pkg::KIND_W-1:0]   kind;
    logic [bst_pkg::SEM_ID_W-1:0] sem_id;

    modport source (output valid, output kind, output sem_id, input ready);
    modport sink   (input valid, input kind, input sem_id, output ready);
endinterface

/* rtl/bst_rsp_if.sv */
// ----------------------------------------------------------------------------
// bst_rsp_if
// Response channel: valid/ready handshake with status, new id and wake.
// ----------------------------------------------------------------------------
interface bst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bst_pkg::STATUS_W-1:0] status;
    logic [bst_pkg::NEW_ID_W-1:0] new_id;
    logic                         wake;

    modport source (output valid, output status, output new_id, output wake, input ready);
    modport sink   (input valid, input status, input new_id, input wake, output ready);
endinterface

/* rtl/bst_table.sv */
// ----------------------------------------------------------------------------
// bst_table
// Semaphore entry store: id memory with registered read, used and released
// flags, and the single compare unit used by the scan.
// ----------------------------------------------------------------------------
module bst_table #(
    parameter int NUM_SEMS = bst_pkg::NUM_SEMS_DEF,
    parameter int ID_BITS  = bst_pkg::ID_BITS_DEF,
    parameter int IDX_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bst_pkg::tbl_cmd_t  cmd,
    input  logic [IDX_W-1:0]   addr,
    input  logic [ID_BITS-1:0] key,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [ID_BITS-1:0] wr_id,
    output bst_pkg::tbl_stat_t st,
    output logic [IDX_W-1:0]   hit_idx
);
    import bst_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SEMS - 1);

    logic [ID_BITS-1:0]  id_mem [NUM_SEMS];
    logic [NUM_SEMS-1:0] used_reg;
    logic [NUM_SEMS-1:0] rel_reg;

    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ID_BITS-1:0]  rd_id_reg;

    logic                id_match;
    logic                key_ok;

    // memory read port, one entry per cycle while rd_en is set
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_id_reg  <= id_mem[addr];
            rd_idx_reg <= addr;
        end
        if (cmd.do_alloc)
        begin
            id_mem[wr_idx] <= wr_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            used_reg   <= '0;
            rel_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_rd)
                rd_vld_reg <= 1'b0;
            else
                rd_vld_reg <= cmd.rd_en;

            if (cmd.do_alloc)
            begin
                used_reg[wr_idx] <= 1'b1;
                rel_reg[wr_idx]  <= 1'b1;
            end
            else if (cmd.do_free)
            begin
                used_reg[wr_idx] <= 1'b0;
                rel_reg[wr_idx]  <= 1'b0;
            end
            else if (cmd.do_take)
                rel_reg[wr_idx] <= 1'b0;
            else if (cmd.do_release)
                rel_reg[wr_idx] <= 1'b1;
        end
    end

    // id zero never matches a live entry
    assign key_ok   = (key != '0);
    assign id_match = used_reg[rd_idx_reg] && (rd_id_reg == key) && key_ok;

    always_comb
    begin
        st         = '0;
        st.rd_vld  = rd_vld_reg;
        st.hit     = rd_vld_reg && (cmd.mode_alloc ? !used_reg[rd_idx_reg] : id_match);
        st.hit_rel = rel_reg[rd_idx_reg];
        st.last    = (rd_idx_reg == LAST_IDX);
    end

    assign hit_idx = rd_idx_reg;

    a_alloc_unused: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_alloc |-> !used_reg[wr_idx])
        else $error("alloc wrote a live entry");

    a_op_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_free || cmd.do_take || cmd.do_release) |-> used_reg[wr_idx])
        else $error("free/down/up applied to an unused entry");

    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_free |=> !used_reg[$past(wr_idx)] && !rel_reg[$past(wr_idx)])
        else $error("freed entry still marked live");

endmodule

/* rtl/binary_semaphore_table.sv */
// ----------------------------------------------------------------------------
// binary_semaphore_table
// Table of binary semaphores with alloc, free, down (try) and up requests.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (kind, sem_id); rsp returns exactly one
//   response word (status, new_id, wake) per request, in order.
//   A request is taken only while the block is idle. The sequencer then
//   scans the entry table one entry per cycle through the single id memory
//   read port and compare unit, stopping at the first match (first unused
//   entry for alloc, live entry with the id otherwise).
//   One request is handled at a time; a new one is taken only after the
//   previous response has been loaded into the output register.
//   The response sits in an output register; the next request is accepted
//   while it waits. If rsp stalls, a finished second request holds in its
//   final step until the register frees, and req stays low meanwhile.
//   Reset clears all entries to unused and the id counter to 1; no clearing
//   pass is needed, the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module binary_semaphore_table #(
    parameter int NUM_SEMS = bst_pkg::NUM_SEMS_DEF,
    parameter int ID_BITS  = bst_pkg::ID_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bst_req_if.sink   req,
    bst_rsp_if.source rsp
);
    import bst_pkg::*;

    localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_SEMS - 1);
    localparam logic [ID_BITS-1:0] TOP_ID   = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    addr_reg;
    logic [ID_BITS-1:0]  next_id_reg;
    logic                out_vld_reg;
    status_t             out_status_reg;
    logic [NEW_ID_W-1:0] out_new_id_reg;
    logic                out_wake_reg;

    kind_t               kind_reg;
    logic [ID_BITS-1:0]  key_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                hit_rel_reg;

    tbl_cmd_t            cmd;
    tbl_stat_t           tbl_st;
    logic [IDX_W-1:0]    tbl_hit_idx;

    logic                accept;
    logic                scan_done;
    logic                load_out;
    logic                bump_id;
    status_t             res_status;
    logic [NEW_ID_W-1:0] res_new_id;
    logic                res_wake;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign scan_done = (state_reg == S_SCAN) && tbl_st.rd_vld && (tbl_st.hit || tbl_st.last);
    assign load_out  = (state_reg == S_FINISH) && (!out_vld_reg || rsp.ready);

    bst_table #(
        .NUM_SEMS (NUM_SEMS),
        .ID_BITS  (ID_BITS),
        .IDX_W    (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .addr    (addr_reg),
        .key     (key_reg),
        .wr_idx  (hit_idx_reg),
        .wr_id   (next_id_reg),
        .st      (tbl_st),
        .hit_idx (tbl_hit_idx)
    );

    // table read control, result and table update for the finished scan
    always_comb
    begin
        cmd            = '0;
        cmd.rd_en      = (state_reg == S_SCAN);
        cmd.clr_rd     = (state_reg == S_IDLE);
        cmd.mode_alloc = (kind_reg == K_ALLOC);
        res_status     = ST_OK;
        res_new_id     = '0;
        res_wake       = 1'b0;
        bump_id        = 1'b0;
        unique case (kind_reg)
            K_ALLOC:
            begin
                if (!found_reg)
                    res_status = ST_FULL;
                else if (next_id_reg == TOP_ID)
                    res_status = ST_EXHAUSTED;
                else
                begin
                    res_new_id   = NEW_ID_W'(next_id_reg);
                    cmd.do_alloc = load_out;
                    bump_id      = load_out;
                end
            end
            K_FREE:
            begin
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else
                    cmd.do_free = load_out;
            end
            K_DOWN:
            begin
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else if (hit_rel_reg)
                    cmd.do_take = load_out;
                else
                    res_status = ST_BUSY;
            end
            K_UP:
            begin
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else
                begin
                    cmd.do_release = load_out;
                    res_wake       = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept)    state_next = S_SCAN;
            S_SCAN:   if (scan_done) state_next = S_FINISH;
            S_FINISH: if (load_out)  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            next_id_reg    <= ID_BITS'(FIRST_ID);
            out_vld_reg    <= 1'b0;
            out_status_reg <= ST_OK;
            out_new_id_reg <= '0;
            out_wake_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
                addr_reg <= '0;
            else if ((state_reg == S_SCAN) && (addr_reg != LAST_IDX))
                addr_reg <= addr_reg + IDX_W'(1);

            if (bump_id)
                next_id_reg <= next_id_reg + ID_BITS'(1);

            if (load_out)
            begin
                out_vld_reg    <= 1'b1;
                out_status_reg <= res_status;
                out_new_id_reg <= res_new_id;
                out_wake_reg   <= res_wake;
            end
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // request word and scan outcome
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_t'(req.kind);
            key_reg  <= ID_BITS'(req.sem_id);
        end
        if (scan_done)
        begin
            found_reg   <= tbl_st.hit;
            hit_idx_reg <= tbl_hit_idx;
            hit_rel_reg <= tbl_st.hit_rel;
        end
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.status = out_status_reg;
    assign rsp.new_id = out_new_id_reg;
    assign rsp.wake   = out_wake_reg;

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("id counter wrapped to zero");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_FINISH))
        else $error("response loaded outside the finish step");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_wake_reg) |-> (out_status_reg == ST_OK) && (out_new_id_reg == '0))
        else $error("wake with a failing status or an id");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary semaphore table. A directed table walks
// the id-zero, no-match, busy, double-release and free cases, then random
// request streams drive the table through empty, full and mixed fill levels.
// The table is then emptied and filled to the last entry for the full case. Each
// response word is checked against a hand-written reply or the behavioral copy.
// ----------------------------------------------------------------------------
module tb;
    import bst_pkg::*;

    localparam int NUM_SEMS = NUM_SEMS_DEF;
    localparam int LIMIT    = 4000000;

    typedef struct {
        status_t             status;
        logic [NEW_ID_W-1:0] new_id;
        logic                wake;
    } reply_t;

    typedef struct {
        kind_t               kind;
        logic [SEM_ID_W-1:0] id;
        bit                  given;
        status_t             status;
        logic [NEW_ID_W-1:0] new_id;
        logic                wake;
    } dir_row_t;

    // rows with given = 1 carry a hand-written reply, the rest use the table copy
    dir_row_t dir_rows [23] = '{
        '{K_FREE,  16'h0000, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_DOWN,  16'h0000, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_UP,    16'h0000, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_FREE,  16'hFFFF, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_ALLOC, 16'h0000, 1'b1, ST_OK,        16'd1, 1'b0},
        '{K_ALLOC, 16'h0000, 1'b1, ST_OK,        16'd2, 1'b0},
        '{K_DOWN,  16'h0001, 1'b1, ST_OK,        16'd0, 1'b0},
        '{K_DOWN,  16'h0001, 1'b1, ST_BUSY,      16'd0, 1'b0},
        '{K_UP,    16'h0001, 1'b1, ST_OK,        16'd0, 1'b1},
        '{K_UP,    16'h0001, 1'b1, ST_OK,        16'd0, 1'b1},
        '{K_DOWN,  16'h0002, 1'b1, ST_OK,        16'd0, 1'b0},
        '{K_FREE,  16'h0002, 1'b1, ST_OK,        16'd0, 1'b0},
        '{K_DOWN,  16'h0002, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_UP,    16'h0002, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_ALLOC, 16'hFFFF, 1'b1, ST_OK,        16'd3, 1'b0},
        '{K_FREE,  16'h0001, 1'b1, ST_OK,        16'd0, 1'b0},
        '{K_ALLOC, 16'h5555, 1'b1, ST_OK,        16'd4, 1'b0},
        '{K_DOWN,  16'h8000, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_UP,    16'h0003, 1'b0, ST_OK,        16'd0, 1'b0},
        '{K_DOWN,  16'h0004, 1'b0, ST_OK,        16'd0, 1'b0},
        '{K_FREE,  16'h0004, 1'b0, ST_OK,        16'd0, 1'b0},
        '{K_UP,    16'h0004, 1'b1, ST_NOT_FOUND, 16'd0, 1'b0},
        '{K_FREE,  16'h0003, 1'b1, ST_OK,        16'd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    bst_req_if req_ch ();
    bst_rsp_if rsp_ch ();

    binary_semaphore_table #(
        .NUM_SEMS (NUM_SEMS),
        .ID_BITS  (ID_BITS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // behavioral copy of the table
    logic                sem_used [NUM_SEMS];
    logic [SEM_ID_W-1:0] sem_key  [NUM_SEMS];
    logic                sem_rel  [NUM_SEMS];
    logic [SEM_ID_W-1:0] id_ctr;

    reply_t pending_replies [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    bit  gaps_on     = 1'b0;
    bit  rx_steady   = 1'b1;
    int  burst_left  = 0;
    int  rx_left     = 0;
    bit  rx_on       = 1'b1;
    logic [SEM_ID_W-1:0] last_freed = '0;

    always #10 clk = ~clk;

    function automatic reply_t table_step(kind_t k, logic [SEM_ID_W-1:0] id);
        reply_t r;
        int     hit;
        r.status = ST_OK;
        r.new_id = '0;
        r.wake   = 1'b0;
        hit      = -1;
        if (k == K_ALLOC)
        begin
            for (int i = 0; i < NUM_SEMS; i++)
                if (!sem_used[i] && hit < 0)
                    hit = i;
            if (hit < 0)
                r.status = ST_FULL;
            else if (id_ctr == '1)
                r.status = ST_EXHAUSTED;
            else
            begin
                r.new_id      = id_ctr;
                sem_used[hit] = 1'b1;
                sem_key[hit]  = id_ctr;
                sem_rel[hit]  = 1'b1;
                id_ctr        = id_ctr + 1'b1;
            end
        end
        else
        begin
            if (id >= FIRST_ID)
                for (int i = 0; i < NUM_SEMS; i++)
                    if (sem_used[i] && sem_key[i] == id && hit < 0)
                        hit = i;
            if (hit < 0)
                r.status = ST_NOT_FOUND;
            else if (k == K_FREE)
            begin
                sem_used[hit] = 1'b0;
                sem_key[hit]  = '0;
                sem_rel[hit]  = 1'b0;
            end
            else if (k == K_DOWN)
            begin
                if (sem_rel[hit])
                    sem_rel[hit] = 1'b0;
                else
                    r.status = ST_BUSY;
            end
            else
            begin
                sem_rel[hit] = 1'b1;
                r.wake       = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report(input string msg);
        if (err_count < 20)
            $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // called at a falling edge; returns at a falling edge after the word is taken
    task automatic send_word(input kind_t k, input logic [SEM_ID_W-1:0] id,
                             input bit given, input reply_t given_rep);
        reply_t want;
        want = table_step(k, id);
        if (given)
            want = given_rep;
        req_ch.valid  <= 1'b1;
        req_ch.kind   <= k;
        req_ch.sem_id <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_replies.push_back(want);
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [SEM_ID_W-1:0] pick_id();
        int sel;
        int j;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            for (int t = 0; t < 8; t++)
            begin
                j = $urandom_range(0, NUM_SEMS - 1);
                if (sem_used[j])
                    return sem_key[j];
            end
            return id_ctr - 1'b1;
        end
        else if (sel < 80)
            return last_freed;
        else if (sel < 90)
            return SEM_ID_W'($urandom);
        else if (sel < 95)
            return '0;
        else
            return ($urandom_range(0, 1) != 0) ? '1 : id_ctr;
    endfunction

    task automatic random_items(input int n, input int alloc_pct);
        kind_t               k;
        logic [SEM_ID_W-1:0] id;
        int                  sel;
        reply_t              none;
        none = '{ST_OK, '0, 1'b0};
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < alloc_pct)
                k = K_ALLOC;
            else
            begin
                sel = $urandom_range(0, 99);
                k = (sel < 25) ? K_FREE : (sel < 65) ? K_DOWN : K_UP;
            end
            id = (k == K_ALLOC) ? SEM_ID_W'($urandom) : pick_id();
            if (k == K_FREE)
                last_freed = id;
            send_word(k, id, 1'b0, none);
        end
    endtask

    // receiver ready pattern: runs of ready and stall, now and then a long stall
    always @(negedge clk)
    begin
        if (rx_steady)
            rsp_ch.ready <= 1'b1;
        else
        begin
            if (rx_left == 0)
            begin
                rx_on = ($urandom_range(0, 9) < 6);
                if (rx_on)
                    rx_left = $urandom_range(1, 8);
                else if ($urandom_range(0, 15) == 0)
                    rx_left = $urandom_range(20, 40);
                else
                    rx_left = $urandom_range(1, 5);
            end
            rx_left--;
            rsp_ch.ready <= rx_on;
        end
    end

    always @(posedge clk)
    begin : rsp_check
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
                report("response word with nothing expected");
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.status !== want.status)
                    report($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
                if (rsp_ch.new_id !== want.new_id)
                    report($sformatf("new_id %h, expected %h", rsp_ch.new_id, want.new_id));
                if (rsp_ch.wake !== want.wake)
                    report($sformatf("wake %b, expected %b", rsp_ch.wake, want.wake));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        reply_t row_rep;
        reply_t none;
        logic [SEM_ID_W-1:0] old_id;
        none          = '{ST_OK, '0, 1'b0};
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.kind   = K_ALLOC;
        req_ch.sem_id = '0;
        rsp_ch.ready  = 1'b0;
        for (int i = 0; i < NUM_SEMS; i++)
        begin
            sem_used[i] = 1'b0;
            sem_key[i]  = '0;
            sem_rel[i]  = 1'b0;
        end
        id_ctr = SEM_ID_W'(FIRST_ID);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        gaps_on   = 1'b1;
        rx_steady = 1'b0;
        foreach (dir_rows[i])
        begin
            row_rep = '{dir_rows[i].status, dir_rows[i].new_id, dir_rows[i].wake};
            send_word(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].given, row_rep);
        end

        // random phases at different fill pressure
        random_items(300, 60);
        wait_drain();
        random_items(400, 20);
        gaps_on   = 1'b0;
        rx_steady = 1'b1;
        random_items(300, 40);
        gaps_on   = 1'b1;
        rx_steady = 1'b0;
        random_items(400, 35);

        // empty the table, then fill every entry
        gaps_on   = 1'b0;
        rx_steady = 1'b1;
        for (int i = 0; i < NUM_SEMS; i++)
            if (sem_used[i])
            begin
                old_id = sem_key[i];
                send_word(K_FREE, old_id, 1'b0, none);
            end
        repeat (NUM_SEMS) send_word(K_ALLOC, '0, 1'b0, none);

        // full table, then one slot freed and taken again by a fresh id
        gaps_on   = 1'b1;
        rx_steady = 1'b0;
        send_word(K_ALLOC, '0, 1'b0, none);
        old_id = id_ctr - 1'b1;
        send_word(K_FREE, old_id, 1'b0, none);
        send_word(K_ALLOC, '0, 1'b0, none);
        send_word(K_FREE, old_id, 1'b0, none);
        send_word(K_DOWN, id_ctr - 1'b1, 1'b0, none);
        send_word(K_DOWN, id_ctr - 1'b1, 1'b0, none);
        send_word(K_UP, id_ctr - 1'b1, 1'b0, none);
        send_word(K_ALLOC, '0, 1'b0, none);
        random_items(150, 30);

        wait_drain();
        repeat (NUM_SEMS + 10) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
